// ----- hw/rtl/ersai_pkg.sv -----
package ersai_pkg;

  // Field widths
  localparam int ECHO_W  = 16;
  localparam int DIST_W  = 10;
  localparam int LEVEL_W = 8;
  localparam int CFG_W   = 10;
  localparam int CIDX_W  = 3;

  // Moving-average window and derived widths
  localparam int WINDOW  = 5;
  localparam int SUM_W   = $clog2(WINDOW * ((2 ** DIST_W) - 1) + 1);
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Echo to distance: floor(echo * 17 / 1000)
  localparam int DIST_NUM   = 17;
  localparam int DIST_DEN   = 1000;
  localparam int SCALED_W   = $clog2(((2 ** ECHO_W) - 1) * DIST_NUM + 1);
  localparam int DIST_SHIFT = 20;
  localparam int DIST_RECIP = (2 ** DIST_SHIFT) / DIST_DEN;
  localparam int DRECIP_W   = $clog2(DIST_RECIP + 1);
  localparam int DPROD_W    = SCALED_W + DRECIP_W;
  localparam int RAWQ_W     = $clog2((((2 ** ECHO_W) - 1) * DIST_NUM) / DIST_DEN + 2);

  // Sum to average: reciprocal of the window
  localparam int AVG_SHIFT  = 16;
  localparam int AVG_RECIP  = (2 ** AVG_SHIFT) / WINDOW;
  localparam int AVG_PW     = SUM_W + AVG_SHIFT + 1;

  // Intensity mapping
  localparam int PROD_W     = DIST_W + 1 + LEVEL_W + 1;
  localparam int DIV_NUM_W  = DIST_W + LEVEL_W;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
  localparam int LVL_SUM_W  = PROD_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_MAX_DIST  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MIN_DIST  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ALERT_THR = 3'd2;
  localparam logic [CIDX_W-1:0] REG_NEAR_INT  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_FAR_INT   = 3'd4;

  // Register reset values
  localparam logic [DIST_W-1:0]  MAX_DIST_RST  = 10'd100;
  localparam logic [DIST_W-1:0]  MIN_DIST_RST  = 10'd5;
  localparam logic [DIST_W-1:0]  ALERT_THR_RST = 10'd40;
  localparam logic [LEVEL_W-1:0] NEAR_INT_RST  = 8'd255;
  localparam logic [LEVEL_W-1:0] FAR_INT_RST   = 8'd100;

  typedef struct packed {
    logic [DIST_W-1:0]  far_limit;
    logic [DIST_W-1:0]  near_limit;
    logic [DIST_W-1:0]  alarm_limit;
    logic [LEVEL_W-1:0] near_intensity;
    logic [LEVEL_W-1:0] far_intensity;
  } cfg_t;

endpackage

// ----- hw/rtl/ersai_div.sv -----
module ersai_div import ersai_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIST_W-1:0]    den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIST_W-1:0]    rem;
  logic [DIST_W-1:0]    divisor;
  logic [DIV_NUM_W-1:0] shreg;
  logic [DIST_W:0]      rem_sh;
  logic                 fits;

  // One restoring step: bring down the next dividend bit
  assign rem_sh = {rem, shreg[DIV_NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, divisor});
  assign quo    = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= DIV_CNT_W'(DIV_NUM_W);
        rem     <= '0;
        divisor <= den;
        shreg   <= num;
      end else if (busy) begin
        rem   <= fits ? DIST_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIST_W-1:0];
        shreg <= {shreg[DIV_NUM_W-2:0], fits};
        cnt   <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/ersai_fifo.sv -----
module ersai_fifo import ersai_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DIST_W-1:0] wr_data,
  input  logic              pop,
  output logic [DIST_W-1:0] rd_data,
  output logic              full,
  output logic              empty
);

  logic [DIST_W-1:0] mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the incoming distance
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/ersai_front.sv -----
module ersai_front import ersai_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ECHO_W-1:0] echo_us,
  input  cfg_t              cfg,
  input  logic              q_full,
  output logic              q_push,
  output logic [DIST_W-1:0] q_data
);

  typedef enum logic [1:0] {F_IDLE, F_SCALE, F_RECIP, F_FIX} fstate_t;

  fstate_t             state;
  logic [ECHO_W-1:0]   echo;
  logic [SCALED_W-1:0] scaled;
  logic [RAWQ_W-1:0]   q_est;
  logic [DPROD_W-1:0]  recip_prod;
  logic [SCALED_W-1:0] back_prod;
  logic [SCALED_W-1:0] rem;
  logic [RAWQ_W-1:0]   raw;
  logic                out_of_range;

  assign in_stall = (state != F_IDLE);

  // Reciprocal estimate, at most one short of the true quotient
  assign recip_prod = DPROD_W'(scaled) * DPROD_W'(DIST_RECIP);

  // Correct the estimate and clamp to the valid range
  assign back_prod    = SCALED_W'(q_est) * SCALED_W'(DIST_DEN);
  assign rem          = scaled - back_prod;
  assign raw          = (rem >= SCALED_W'(DIST_DEN)) ? q_est + 1'b1 : q_est;
  assign out_of_range = (raw == '0) || (raw > RAWQ_W'(cfg.far_limit));
  assign q_data       = out_of_range ? cfg.far_limit : raw[DIST_W-1:0];
  assign q_push       = (state == F_FIX) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            echo  <= echo_us;
            state <= F_SCALE;
          end
        end
        F_SCALE: begin
          scaled <= SCALED_W'(echo) * SCALED_W'(DIST_NUM);
          state  <= F_RECIP;
        end
        F_RECIP: begin
          q_est <= recip_prod[DIST_SHIFT +: RAWQ_W];
          state <= F_FIX;
        end
        F_FIX: begin
          // Hold until the queue has room
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ersai_back.sv -----
module ersai_back import ersai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  logic [DIST_W-1:0]  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DIST_W-1:0]  raw_distance_cm,
  output logic [DIST_W-1:0]  smooth_distance_cm,
  output logic [LEVEL_W-1:0] alert_level,
  output logic               alert_active
);

  typedef enum logic [3:0] {
    B_IDLE, B_SUM, B_AVG, B_FIX, B_MUL, B_DIVGO, B_DIVWAIT, B_ADD, B_OUT
  } bstate_t;

  bstate_t                  state;
  logic [DIST_W-1:0]        ring [WINDOW];
  logic [SLOT_W-1:0]        slot;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-1:0]         sum_next;
  logic [DIST_W-1:0]        raw;
  logic [SUM_W-1:0]         q_avg;
  logic [AVG_PW-1:0]        avg_prod;
  logic [SUM_W-1:0]         avg_rem;
  logic [SUM_W-1:0]         avg_full;
  logic [DIST_W-1:0]        smooth;
  logic                     active;
  logic                     flat;
  logic signed [DIST_W:0]   diff;
  logic signed [LEVEL_W:0]  span;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_mag;
  logic                     neg;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_NUM_W-1:0]     div_num;
  logic [DIST_W-1:0]        div_den;
  logic [DIV_NUM_W-1:0]     div_quo;
  logic [DIV_NUM_W-1:0]     quo;
  logic signed [LVL_SUM_W-1:0] lvl_sum;
  logic [LEVEL_W-1:0]       level_clamped;
  logic [LEVEL_W-1:0]       level;

  assign q_pop = (state == B_IDLE) && !q_empty;

  // Running sum update
  assign sum_next = sum - SUM_W'(ring[slot]) + SUM_W'(raw);

  // Average by reciprocal, then one correction step
  assign avg_prod = AVG_PW'(sum) * AVG_PW'(AVG_RECIP);
  assign avg_rem  = sum - SUM_W'(q_avg * SUM_W'(WINDOW));
  assign avg_full = (avg_rem >= SUM_W'(WINDOW)) ? q_avg + 1'b1 : q_avg;

  // Linear map operands
  assign flat = (cfg.alarm_limit <= cfg.near_limit);
  assign diff = $signed({1'b0, smooth}) - $signed({1'b0, cfg.near_limit});
  assign span = $signed({1'b0, cfg.far_intensity}) - $signed({1'b0, cfg.near_intensity});

  // Divide the magnitude, restore the sign afterwards (truncate toward zero)
  assign prod_mag  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign div_num   = prod_mag[DIV_NUM_W-1:0];
  assign div_den   = cfg.alarm_limit - cfg.near_limit;
  assign div_start = (state == B_DIVGO);

  assign lvl_sum = (neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo}))
                 + $signed({{(LVL_SUM_W-LEVEL_W){1'b0}}, cfg.near_intensity});

  always_comb begin
    if (lvl_sum < 0) begin
      level_clamped = '0;
    end else if (lvl_sum > $signed(LVL_SUM_W'(2 ** LEVEL_W - 1))) begin
      level_clamped = '1;
    end else begin
      level_clamped = lvl_sum[LEVEL_W-1:0];
    end
  end

  ersai_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      slot      <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
    end else begin
      // Drop the result once it has been taken, unless the next one loads now
      if (out_valid && !out_stall && state != B_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            raw   <= q_data;
            state <= B_SUM;
          end
        end
        B_SUM: begin
          sum        <= sum_next;
          ring[slot] <= raw;
          slot       <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
          state      <= B_AVG;
        end
        B_AVG: begin
          q_avg <= avg_prod[AVG_SHIFT +: SUM_W];
          state <= B_FIX;
        end
        B_FIX: begin
          smooth <= avg_full[DIST_W-1:0];
          active <= (avg_full[DIST_W-1:0] <= cfg.alarm_limit);
          state  <= B_MUL;
        end
        B_MUL: begin
          prod  <= diff * span;
          state <= (active && !flat) ? B_DIVGO : B_ADD;
        end
        B_DIVGO: begin
          neg   <= prod[PROD_W-1];
          state <= B_DIVWAIT;
        end
        B_DIVWAIT: begin
          if (div_done) begin
            quo   <= div_quo;
            state <= B_ADD;
          end
        end
        B_ADD: begin
          if (!active) begin
            level <= '0;
          end else if (flat) begin
            level <= cfg.near_intensity;
          end else begin
            level <= level_clamped;
          end
          state <= B_OUT;
        end
        B_OUT: begin
          // Load the output register once it is free
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            raw_distance_cm    <= raw;
            smooth_distance_cm <= smooth;
            alert_level        <= level;
            alert_active       <= active;
            state              <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/echo_range_smoother_alert_intensity.sv -----
// The intensity divide is skipped with no alert or a threshold not above the minimum.
// The back end and its 18-step restoring divider set the pace; the front end converts
// the next echo meanwhile.
// Reset (rst, synchronous): registers to their defaults, sample ring, sum and
// slot to zero, queue empty, no result pending.
module echo_range_smoother_alert_intensity import ersai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ECHO_W-1:0]  echo_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DIST_W-1:0]  raw_distance_cm,
  output logic [DIST_W-1:0]  smooth_distance_cm,
  output logic [LEVEL_W-1:0] alert_level,
  output logic               alert_active,
  input  logic               cfg_write,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cfg_t              cfg;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [DIST_W-1:0] q_wr_data;
  logic [DIST_W-1:0] q_rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.far_limit      <= MAX_DIST_RST;
      cfg.near_limit     <= MIN_DIST_RST;
      cfg.alarm_limit    <= ALERT_THR_RST;
      cfg.near_intensity <= NEAR_INT_RST;
      cfg.far_intensity  <= FAR_INT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_DIST:  cfg.far_limit      <= cfg_data[DIST_W-1:0];
        REG_MIN_DIST:  cfg.near_limit     <= cfg_data[DIST_W-1:0];
        REG_ALERT_THR: cfg.alarm_limit    <= cfg_data[DIST_W-1:0];
        REG_NEAR_INT:  cfg.near_intensity <= cfg_data[LEVEL_W-1:0];
        REG_FAR_INT:   cfg.far_intensity  <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  ersai_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .echo_us  (echo_us),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  ersai_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  ersai_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .q_empty            (q_empty),
    .q_data             (q_rd_data),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .raw_distance_cm    (raw_distance_cm),
    .smooth_distance_cm (smooth_distance_cm),
    .alert_level        (alert_level),
    .alert_active       (alert_active)
  );

`ifndef SYNTHESIS
  // The front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("queue push while full");

  // The back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("queue pop while empty");

  // No intensity without an alert
  a_level_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !alert_active) |-> (alert_level == '0))
    else $error("nonzero level without alert");

  // An active alert agrees with the threshold
  a_alert_thr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alert_active) |-> (smooth_distance_cm <= cfg.alarm_limit))
    else $error("alert above threshold");
`endif

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import ersai_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the last register; writes there must be ignored
  localparam logic [CIDX_W-1:0] REG_SPARE_FIRST = REG_FAR_INT + 3'd1;
  localparam logic [CIDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam int IDLE_PCT    = 34;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DIST_W-1:0]  raw;
    logic [DIST_W-1:0]  smooth;
    logic [LEVEL_W-1:0] level;
    logic               active;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ECHO_W-1:0]  echo_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DIST_W-1:0]  raw_distance_cm;
  logic [DIST_W-1:0]  smooth_distance_cm;
  logic [LEVEL_W-1:0] alert_level;
  logic               alert_active;
  logic               cfg_write = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  echo_range_smoother_alert_intensity dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .echo_us            (echo_us),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .raw_distance_cm    (raw_distance_cm),
    .smooth_distance_cm (smooth_distance_cm),
    .alert_level        (alert_level),
    .alert_active       (alert_active),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #4 clk = ~clk;

  // Mirror of the registers and of the averaging state
  logic [DIST_W-1:0]  max_cm   = MAX_DIST_RST;
  logic [DIST_W-1:0]  min_cm   = MIN_DIST_RST;
  logic [DIST_W-1:0]  thr_cm   = ALERT_THR_RST;
  logic [LEVEL_W-1:0] near_lvl = NEAR_INT_RST;
  logic [LEVEL_W-1:0] far_lvl  = FAR_INT_RST;
  logic [DIST_W-1:0]  ring [WINDOW];
  int unsigned        ring_sum  = 0;
  int unsigned        ring_slot = 0;

  logic [ECHO_W-1:0]  pending_echoes[$];
  reading_t           awaited_readings[$];
  bit                 steady = 1'b0;
  int                 errors = 0;
  int                 quiet_cycles = 0;
  int unsigned        aim_cm = 20;

  initial begin
    foreach (ring[i]) ring[i] = '0;
  end

  // Convert, average and grade one echo; queue the reading it must give
  task automatic track_echo(input logic [ECHO_W-1:0] echo);
    int unsigned dist_cm;
    int unsigned avg;
    int          lo;
    int          hi;
    int          nr;
    int          fr;
    int          v;
    reading_t    r;
    dist_cm = (int'(echo) * DIST_NUM) / DIST_DEN;
    if (dist_cm == 0 || dist_cm > max_cm) dist_cm = 32'(max_cm);
    ring_sum = ring_sum - ring[ring_slot] + dist_cm;
    ring[ring_slot] = dist_cm[DIST_W-1:0];
    ring_slot = (ring_slot + 1) % WINDOW;
    avg = ring_sum / WINDOW;
    r = '0;
    r.raw = dist_cm[DIST_W-1:0];
    r.smooth = avg[DIST_W-1:0];
    if (avg <= thr_cm) begin
      r.active = 1'b1;
      lo = int'(min_cm);
      hi = int'(thr_cm);
      nr = int'(near_lvl);
      fr = int'(far_lvl);
      if (hi <= lo) begin
        v = nr;
      end else begin
        // signed division truncates toward zero, as required below minimum
        v = nr + ((int'(avg) - lo) * (fr - nr)) / (hi - lo);
      end
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      r.level = v[LEVEL_W-1:0];
    end
    awaited_readings.push_back(r);
  endtask

  // Sender: present queued echoes, idle at random, predict on each transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_echo(echo_us);
      if (!in_valid || !in_stall) begin
        if (pending_echoes.size() > 0 &&
            (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          echo_us <= pending_echoes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, compare each transfer with the oldest reading
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_readings.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected reading: raw %0d smooth %0d level %0d active %0b",
                     raw_distance_cm, smooth_distance_cm, alert_level, alert_active);
        end else begin
          want = awaited_readings.pop_front();
          if (raw_distance_cm !== want.raw || smooth_distance_cm !== want.smooth ||
              alert_level !== want.level || alert_active !== want.active) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("reading mismatch: raw %0d/%0d smooth %0d/%0d level %0d/%0d active %0b/%0b",
                       want.raw, raw_distance_cm, want.smooth, smooth_distance_cm,
                       want.level, alert_level, want.active, alert_active);
          end
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog: give up after a long stretch with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register while the block is idle and update the mirror
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MAX_DIST:  max_cm = data;
      REG_MIN_DIST:  min_cm = data;
      REG_ALERT_THR: thr_cm = data;
      REG_NEAR_INT:  near_lvl = data[LEVEL_W-1:0];
      REG_FAR_INT:   far_lvl = data[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned mx, input int unsigned mn, input int unsigned th,
                          input int unsigned nr, input int unsigned fr);
    write_reg(REG_MAX_DIST, CFG_W'(mx));
    write_reg(REG_MIN_DIST, CFG_W'(mn));
    write_reg(REG_ALERT_THR, CFG_W'(th));
    write_reg(REG_NEAR_INT, CFG_W'(nr));
    write_reg(REG_FAR_INT, CFG_W'(fr));
  endtask

  // Hold until every queued echo has gone and every reading has come back
  task automatic drain();
    @(negedge clk);
    while (pending_echoes.size() > 0 || in_valid || awaited_readings.size() > 0)
      @(negedge clk);
  endtask

  // Mostly echoes that track a slowly drifting distance near the threshold,
  // with some timeouts, near-zero readings and full-range noise
  task automatic queue_echoes(input int n);
    int unsigned roll;
    int unsigned e;
    int          step;
    @(negedge clk);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        e = $urandom_range(0, 65535);
      end else if (roll < 12) begin
        e = $urandom_range(0, 58);
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          aim_cm = $urandom_range(0, thr_cm + thr_cm / 2 + 10);
        end else begin
          step = int'(aim_cm) + $urandom_range(0, 6) - 3;
          aim_cm = (step < 0) ? 0 : step;
        end
        e = aim_cm * 59 + $urandom_range(0, 58);
        if (e > 65535) e = 65535;
      end
      pending_echoes.push_back(e[ECHO_W-1:0]);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Defaults: timeouts, zero and over-range readings, warm-up, below minimum
    pending_echoes.push_back(16'd0);
    pending_echoes.push_back(16'd1);
    pending_echoes.push_back(16'd58);
    pending_echoes.push_back(16'd59);
    pending_echoes.push_back(16'd5882);
    pending_echoes.push_back(16'd5941);
    pending_echoes.push_back(16'd6000);
    pending_echoes.push_back(16'hFFFF);
    pending_echoes.push_back(16'hAAAA);
    pending_echoes.push_back(16'h5555);
    pending_echoes.push_back(16'h8000);
    repeat (5) pending_echoes.push_back(16'd589);
    repeat (4) pending_echoes.push_back(16'd295);
    repeat (4) pending_echoes.push_back(16'd118);
    pending_echoes.push_back(16'd2353);
    drain();

    // Widest range, everything alerts, no idling on either side
    steady = 1'b1;
    set_regs(1023, 0, 1023, 0, 255);
    queue_echoes(100);
    drain();
    steady = 1'b0;

    // Threshold not above minimum: level stays at the near intensity
    set_regs(200, 50, 30, 77, 200);
    queue_echoes(100);
    drain();

    // Zero maximum, masked intensity write and ignored spare indexes
    set_regs(0, 0, 0, 1023, 0);
    for (int k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++) write_reg(CIDX_W'(k), 10'h3FF);
    queue_echoes(20);
    drain();

    // Far below minimum: map goes negative, clamp to zero while active;
    // pause the sender half way until all readings are back
    set_regs(1023, 500, 600, 0, 255);
    aim_cm = 550;
    queue_echoes(50);
    drain();
    queue_echoes(50);
    drain();

    // Random register settings
    repeat (3) begin
      set_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 1023), $urandom_range(0, 1023));
      queue_echoes(80);
      drain();
    end

    // Back to the reset values, with extrapolation above 255
    set_regs(MAX_DIST_RST, MIN_DIST_RST, ALERT_THR_RST, NEAR_INT_RST, FAR_INT_RST);
    aim_cm = 10;
    queue_echoes(60);
    drain();

    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && awaited_readings.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ersai_pkg.sv
hw/rtl/ersai_div.sv
hw/rtl/ersai_fifo.sv
hw/rtl/ersai_front.sv
hw/rtl/ersai_back.sv
hw/rtl/echo_range_smoother_alert_intensity.sv
tb/testbench.sv
